FILE: rtl/wss_pkg.sv
// wss_pkg: shared types and constants of the wake score smoother and trigger
// holds field widths, register indexes, reset values, fsm states and the
// command/status structs between controller and datapath; no dependencies
package wss_pkg;

  // default ring depth handed to the top level
  localparam int RING_DEPTH_DEF = 16;

  // field widths
  localparam int SCORE_W  = 16;
  localparam int TIME_W   = 48;
  localparam int HOLD_W   = 49;
  localparam int THR_W    = 16;
  localparam int WLEN_W   = 5;
  localparam int WARM_W   = 20;
  localparam int COOL_W   = 16;
  localparam int STRIDE_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_STRIDE = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]    THRESHOLD_RST = 16'd16384;
  localparam logic [WLEN_W-1:0]   WLEN_RST      = 5'd5;
  localparam logic [WARM_W-1:0]   WARMUP_RST    = 20'd216;
  localparam logic [COOL_W-1:0]   COOLDOWN_RST  = 16'd1500;
  localparam logic [STRIDE_W-1:0] STRIDE_RST    = 5'd1;

  // warm-up counter saturation value
  localparam logic [WARM_W-1:0] WARM_MAX = '1;

  // event kinds
  typedef enum logic {
    EVT_REPORT = 1'b0,
    EVT_DETECT = 1'b1
  } event_kind_t;

  // configuration register set
  typedef struct packed {
    logic [THR_W-1:0]    detect_level;
    logic [WLEN_W-1:0]   window_length;
    logic [WARM_W-1:0]   warmup_frames;
    logic [COOL_W-1:0]   holdoff_ms;
    logic [STRIDE_W-1:0] feature_stride;
  } cfg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_SUM,
    S_DIV,
    S_DECIDE,
    S_EMIT0,
    S_EMIT1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        wrap;
    logic        sum_start;
    logic        sum_run;
    logic        div_start;
    logic        div_run;
    logic        decide;
    logic        emit;
    event_kind_t emit_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wrap_done;
    logic sum_done;
    logic div_done;
    logic detect;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/wss_ctrl.sv
// wss_ctrl: sequencing state machine of the wake score smoother and trigger
// steps each item through wrap, sum, divide, decide and emit phases
// depends on wss_pkg
module wss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wss_pkg::status_t status,
  output wss_pkg::cmd_t    cmd
);

  wss_pkg::state_t state_r;
  wss_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = wss_pkg::EVT_REPORT;
    in_ready      = 1'b0;
    unique case (state_r)
      wss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = wss_pkg::S_WRAP;
        end
      end
      wss_pkg::S_WRAP: begin
        if (status.wrap_done) begin
          cmd.sum_start = 1'b1;
          state_nxt     = wss_pkg::S_SUM;
        end else begin
          cmd.wrap = 1'b1;
        end
      end
      wss_pkg::S_SUM: begin
        if (status.sum_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = wss_pkg::S_DIV;
        end else begin
          cmd.sum_run = 1'b1;
        end
      end
      wss_pkg::S_DIV: begin
        if (status.div_done) begin
          state_nxt = wss_pkg::S_DECIDE;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      wss_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = wss_pkg::S_EMIT0;
      end
      wss_pkg::S_EMIT0: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = wss_pkg::EVT_REPORT;
          state_nxt     = status.detect ? wss_pkg::S_EMIT1 : wss_pkg::S_IDLE;
        end
      end
      wss_pkg::S_EMIT1: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = wss_pkg::EVT_DETECT;
          state_nxt     = wss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wss_pkg::S_IDLE;
      end
    endcase
  end

  // a beat is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("beat loaded into busy output register");

  // the detect beat only follows a positive decision
  a_emit1_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wss_pkg::S_EMIT1) |-> status.detect)
    else $error("detect beat without detection");

  // divider needs at least one step after start
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !status.div_done)
    else $error("divider finished without stepping");

endmodule

FILE: rtl/wss_datapath.sv
// wss_datapath: score ring, window summing, mean divider, warm-up and hold-off
// tracking, and the output register of the wake score smoother and trigger
// depends on wss_pkg; driven by wss_ctrl
module wss_datapath #(
  parameter int RING_DEPTH = wss_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wss_pkg::cfg_t                  cfg,
  input  wss_pkg::cmd_t                  cmd,
  output wss_pkg::status_t               status,
  input  logic [wss_pkg::SCORE_W-1:0]    in_raw_score,
  input  logic [wss_pkg::TIME_W-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_event_kind,
  output logic [wss_pkg::SCORE_W-1:0]    out_mean_score,
  output logic [wss_pkg::SCORE_W-1:0]    out_raw_echo,
  output logic                           out_last
);

  localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = wss_pkg::SCORE_W + $clog2(RING_DEPTH + 1);
  localparam int CNT_W = $clog2(SUM_W + 1);

  // ring storage
  logic [wss_pkg::SCORE_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]       ring_vld_r;
  logic [wss_pkg::SCORE_W-1:0] rd_data_r;

  logic [LEN_W-1:0]            pos_r;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            idx_r;
  logic                        rd_pend_r;
  logic [SUM_W-1:0]            sum_r;

  logic [SUM_W-1:0]            dvd_r;
  logic [LEN_W-1:0]            rem_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [LEN_W:0]              rem_sh;
  logic                        q_bit;

  logic [wss_pkg::WARM_W-1:0]  warm_cnt_r;
  logic [wss_pkg::WARM_W-1:0]  warm_cnt_nxt;
  logic [wss_pkg::WARM_W:0]    warm_sum;
  logic                        warm_r;

  logic [wss_pkg::HOLD_W-1:0]  holdoff_r;
  logic [wss_pkg::SCORE_W-1:0] raw_r;
  logic [wss_pkg::TIME_W-1:0]  now_r;
  logic [wss_pkg::SCORE_W-1:0] quot;
  logic [wss_pkg::SCORE_W-1:0] mean_r;
  logic                        detect_r;
  logic                        detect_nxt;

  logic                        out_vld_r;
  logic                        out_kind_r;
  logic [wss_pkg::SCORE_W-1:0] out_mean_r;
  logic [wss_pkg::SCORE_W-1:0] out_raw_r;
  logic                        out_last_r;

  // effective window length: zero acts as one, clipped to the ring depth
  always_comb begin
    if (cfg.window_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(cfg.window_length) > RING_DEPTH) begin
      len = LEN_W'(RING_DEPTH);
    end else begin
      len = LEN_W'(cfg.window_length);
    end
  end

  // warm-up counter step with saturation
  always_comb begin
    warm_sum     = {1'b0, warm_cnt_r} + (wss_pkg::WARM_W + 1)'(cfg.feature_stride);
    warm_cnt_nxt = warm_cnt_r;
    if (warm_cnt_r < cfg.warmup_frames) begin
      warm_cnt_nxt = warm_sum[wss_pkg::WARM_W] ? wss_pkg::WARM_MAX
                                               : warm_sum[wss_pkg::WARM_W-1:0];
    end
  end

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_mem[pos_r[POS_W-1:0]] <= in_raw_score;
    end
    rd_data_r <= ring_vld_r[idx_r[POS_W-1:0]] ? ring_mem[idx_r[POS_W-1:0]] : '0;
  end

  // per-entry valid bits stand in for clearing the ring at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
    end else if (cmd.load) begin
      ring_vld_r[pos_r[POS_W-1:0]] <= 1'b1;
    end
  end

  // ring position: advance on load, then fold back below the window length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.load) begin
      pos_r <= pos_r + LEN_W'(1);
    end else if (cmd.wrap) begin
      pos_r <= pos_r - len;
    end
  end

  // capture of the item and warm-up state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
      warm_r     <= 1'b0;
    end else if (cmd.load) begin
      warm_cnt_r <= warm_cnt_nxt;
      warm_r     <= (warm_cnt_nxt >= cfg.warmup_frames);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r <= in_raw_score;
      now_r <= in_now_ms;
    end
  end

  // window sum, one ring entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
    end else if (cmd.sum_start) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
    end else if (cmd.sum_run) begin
      if (idx_r < len) begin
        idx_r     <= idx_r + LEN_W'(1);
        rd_pend_r <= 1'b1;
      end else begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      sum_r <= '0;
    end else if (cmd.sum_run && rd_pend_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, len});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= CNT_W'(SUM_W);
    end else if (cmd.div_run) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.div_run) begin
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
      rem_r <= q_bit ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
    end
  end

  // decision against threshold and hold-off
  assign quot       = dvd_r[wss_pkg::SCORE_W-1:0];
  assign detect_nxt = warm_r && (quot >= cfg.detect_level)
                      && ({1'b0, now_r} >= holdoff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= '0;
      detect_r  <= 1'b0;
    end else if (cmd.decide) begin
      detect_r <= detect_nxt;
      if (detect_nxt) begin
        holdoff_r <= {1'b0, now_r} + wss_pkg::HOLD_W'(cfg.holdoff_ms);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      mean_r <= warm_r ? quot : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_mean_r <= mean_r;
      out_raw_r  <= raw_r;
      out_last_r <= (cmd.emit_kind == wss_pkg::EVT_DETECT) || !detect_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_mean_score = out_mean_r;
  assign out_raw_echo   = out_raw_r;
  assign out_last       = out_last_r;

  // status back to the controller
  always_comb begin
    status           = '0;
    status.wrap_done = (pos_r < len);
    status.sum_done  = (idx_r == len) && !rd_pend_r;
    status.div_done  = (cnt_r == '0);
    status.detect    = detect_r;
    status.out_free  = !out_vld_r || out_ready;
  end

  // ring position never runs past the ring
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LEN_W'(RING_DEPTH))
    else $error("ring position out of range");

  // position is back inside the window before summing starts
  a_pos_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_start |-> (pos_r < len))
    else $error("ring position not folded into window");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_run |-> (rem_r < len))
    else $error("divider remainder out of range");

endmodule

FILE: rtl/wake_score_smoother_trigger_top.sv
// wake_score_smoother_trigger_top: top level of the wake score smoother and trigger
// holds the configuration registers and joins wss_ctrl and wss_datapath
// depends on wss_pkg, wss_ctrl, wss_datapath
//
//   port group | dir | contents
//   in_*       | in  | tdata: raw_score[15:0], now_ms[63:16]
//   out_*      | out | tdata: mean_score[15:0], raw_echo[31:16]; tuser: event_kind; tlast
//   cfg_*      | in  | write enable, register index, write data
//
// the window sum reads one ring entry per cycle and the mean divider makes one
// quotient bit per cycle over SUM_W dividend bits, SUM_W = 16 + clog2(RING_DEPTH + 1);
// a shortened window adds fold-back steps
// a detection adds one output beat; each beat waits while the output register is held
// reset is synchronous; ring entries read as zero until written
// the next item is accepted as soon as the previous one has been handed to the
// output register, even if its last beat has not been taken yet
module wake_score_smoother_trigger_top #(
  parameter int RING_DEPTH = wss_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,   // raw_score, now_ms
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // mean_score, raw_echo
  output logic [0:0]                        out_tuser,  // event_kind
  output logic                              out_tlast,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  wss_pkg::cfg_t    cfg_r;
  wss_pkg::cmd_t    cmd;
  wss_pkg::status_t status;

  logic                        out_kind;
  logic [wss_pkg::SCORE_W-1:0] out_mean;
  logic [wss_pkg::SCORE_W-1:0] out_raw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_level   <= wss_pkg::THRESHOLD_RST;
      cfg_r.window_length  <= wss_pkg::WLEN_RST;
      cfg_r.warmup_frames  <= wss_pkg::WARMUP_RST;
      cfg_r.holdoff_ms     <= wss_pkg::COOLDOWN_RST;
      cfg_r.feature_stride <= wss_pkg::STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wss_pkg::REG_DETECT_LEVEL:   cfg_r.detect_level   <= cfg_wdata[wss_pkg::THR_W-1:0];
        wss_pkg::REG_WINDOW_LENGTH:  cfg_r.window_length  <= cfg_wdata[wss_pkg::WLEN_W-1:0];
        wss_pkg::REG_WARMUP_FRAMES:  cfg_r.warmup_frames  <= cfg_wdata[wss_pkg::WARM_W-1:0];
        wss_pkg::REG_HOLDOFF_MS:     cfg_r.holdoff_ms     <= cfg_wdata[wss_pkg::COOL_W-1:0];
        wss_pkg::REG_FEATURE_STRIDE: cfg_r.feature_stride <= cfg_wdata[wss_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller
  wss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  wss_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .status         (status),
    .in_raw_score   (in_tdata[15:0]),
    .in_now_ms      (in_tdata[63:16]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_event_kind (out_kind),
    .out_mean_score (out_mean),
    .out_raw_echo   (out_raw),
    .out_last       (out_tlast)
  );

  // result beat packing
  assign out_tdata = {out_raw, out_mean};
  assign out_tuser = out_kind;

endmodule

FILE: bench/tb_wake_score_smoother_trigger_top.sv
// testbench for wake_score_smoother_trigger_top: drives score beats and register writes,
// predicts every report and detection and checks each output beat in order
// depends on wss_pkg and the rtl of wake_score_smoother_trigger_top
module tb_wake_score_smoother_trigger_top;

  localparam int DEPTH         = wss_pkg::RING_DEPTH_DEF;
  localparam int RANDOM_BEATS  = 1100;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [wss_pkg::TIME_W-1:0] TIME_MAX = '1;

  // one row of the directed table: either a register write or a score beat
  typedef struct packed {
    logic                           is_write;
    logic [wss_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [wss_pkg::CFG_DATA_W-1:0] reg_val;
    logic [wss_pkg::SCORE_W-1:0]    raw;
    logic [wss_pkg::TIME_W-1:0]     now;
    logic                           typed;
    logic [1:0]                     typed_count;
    logic [wss_pkg::SCORE_W-1:0]    typed_mean;
  } stim_row_t;

  // one result beat as it should leave the block
  typedef struct packed {
    wss_pkg::event_kind_t        kind;
    logic [wss_pkg::SCORE_W-1:0] mean;
    logic [wss_pkg::SCORE_W-1:0] raw;
    logic                        last;
  } score_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;  // raw_score[15:0], now_ms[63:16]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;      // mean_score[15:0], raw_echo[31:16]
  logic [0:0] out_tuser;       // event_kind
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [wss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  wake_score_smoother_trigger_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // mirror of the register set
  logic [wss_pkg::THR_W-1:0]    thr_r    = wss_pkg::THRESHOLD_RST;
  logic [wss_pkg::WLEN_W-1:0]   wlen_r   = wss_pkg::WLEN_RST;
  logic [wss_pkg::WARM_W-1:0]   warm_r   = wss_pkg::WARMUP_RST;
  logic [wss_pkg::COOL_W-1:0]   cool_r   = wss_pkg::COOLDOWN_RST;
  logic [wss_pkg::STRIDE_W-1:0] stride_r = wss_pkg::STRIDE_RST;

  // mirror of the smoother state
  logic [wss_pkg::SCORE_W-1:0] recent_scores [DEPTH];
  int unsigned                 write_slot = 0;
  logic [wss_pkg::WARM_W-1:0]  frames_seen = '0;
  logic [wss_pkg::HOLD_W-1:0]  rearm_at = '0;

  score_event_t pending_events[$];
  stim_row_t    opening_rows[$];
  stim_row_t    closing_rows[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned detects_seen = 0;
  int unsigned settings_used = 0;
  int unsigned send_gap_max = 4;
  int unsigned stall_max = 4;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  // random stream state
  bit                         speaking = 1'b0;
  logic [wss_pkg::TIME_W-1:0] clock_ms = 48'd200000;

  initial begin
    for (int i = 0; i < DEPTH; i++) recent_scores[i] = '0;
  end

  // writes the score into the ring, advances warm-up and decides on a detection
  function automatic void smooth_and_decide(input logic [wss_pkg::SCORE_W-1:0] raw,
                                            input logic [wss_pkg::TIME_W-1:0] now,
                                            output int unsigned count,
                                            output logic [wss_pkg::SCORE_W-1:0] mean);
    int unsigned len;
    logic [19:0] sum;
    logic [20:0] bumped;
    bit warm;
    len = (wlen_r == 0) ? 1 : ((wlen_r > DEPTH) ? DEPTH : int'(wlen_r));
    recent_scores[write_slot] = raw;
    write_slot = (write_slot + 1) % len;
    if (frames_seen < warm_r) begin
      bumped = {1'b0, frames_seen} + 21'(stride_r);
      frames_seen = (bumped > {1'b0, wss_pkg::WARM_MAX}) ? wss_pkg::WARM_MAX
                                                          : bumped[wss_pkg::WARM_W-1:0];
    end
    warm = (frames_seen >= warm_r);
    sum = '0;
    for (int i = 0; i < len; i++) sum = sum + 20'(recent_scores[i]);
    mean = warm ? wss_pkg::SCORE_W'(sum / len) : '0;
    if (warm && mean >= thr_r && {1'b0, now} >= rearm_at) begin
      rearm_at = {1'b0, now} + wss_pkg::HOLD_W'(cool_r);
      count = 2;
    end else begin
      count = 1;
    end
  endfunction

  function automatic stim_row_t item_row(input logic [wss_pkg::SCORE_W-1:0] raw,
                                         input logic [wss_pkg::TIME_W-1:0] now);
    stim_row_t r;
    r = '0;
    r.raw = raw;
    r.now = now;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [wss_pkg::SCORE_W-1:0] raw,
                                          input logic [wss_pkg::TIME_W-1:0] now,
                                          input logic [1:0] count,
                                          input logic [wss_pkg::SCORE_W-1:0] mean);
    stim_row_t r;
    r = item_row(raw, now);
    r.typed = 1'b1;
    r.typed_count = count;
    r.typed_mean = mean;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [wss_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [wss_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // result side: check each beat, then draw the stall before the next one
  always @(posedge clk) begin
    score_event_t exp_evt;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual mean %0d raw %0d kind %0d",
                   $time, out_tdata[15:0], out_tdata[31:16], out_tuser[0]);
          mismatch_count++;
        end else begin
          exp_evt = pending_events.pop_front();
          compare_field("event_kind", 32'(exp_evt.kind), 32'(out_tuser[0]));
          compare_field("mean_score", 32'(exp_evt.mean), 32'(out_tdata[15:0]));
          compare_field("raw_echo", 32'(exp_evt.raw), 32'(out_tdata[31:16]));
          compare_field("last", 32'(exp_evt.last), 32'(out_tlast));
          if (exp_evt.kind == wss_pkg::EVT_DETECT) detects_seen++;
          else reports_seen++;
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sends one score beat and queues what it should cause
  task automatic send_beat(input logic [wss_pkg::SCORE_W-1:0] raw,
                           input logic [wss_pkg::TIME_W-1:0] now,
                           input logic typed, input logic [1:0] typed_count,
                           input logic [wss_pkg::SCORE_W-1:0] typed_mean);
    int unsigned gap;
    int unsigned count;
    logic [wss_pkg::SCORE_W-1:0] mean;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    smooth_and_decide(raw, now, count, mean);
    if (typed) begin
      count = 32'(typed_count);
      mean = typed_mean;
    end
    pending_events.push_back({wss_pkg::EVT_REPORT, mean, raw, count == 1});
    if (count == 2) pending_events.push_back({wss_pkg::EVT_DETECT, mean, raw, 1'b1});
    beats_sent++;
  endtask

  // stop sending and wait for every queued result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // block idle: drained plus its worst-case latency
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wss_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      wss_pkg::REG_DETECT_LEVEL:   thr_r = val[wss_pkg::THR_W-1:0];
      wss_pkg::REG_WINDOW_LENGTH:  wlen_r = val[wss_pkg::WLEN_W-1:0];
      wss_pkg::REG_WARMUP_FRAMES:  warm_r = val[wss_pkg::WARM_W-1:0];
      wss_pkg::REG_HOLDOFF_MS:     cool_r = val[wss_pkg::COOL_W-1:0];
      wss_pkg::REG_FEATURE_STRIDE: stride_r = val[wss_pkg::STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_rows(ref stim_row_t rows[$]);
    foreach (rows[k]) begin
      if (rows[k].is_write) begin
        settle();
        write_reg(rows[k].reg_idx, rows[k].reg_val);
      end else begin
        send_beat(rows[k].raw, rows[k].now, rows[k].typed, rows[k].typed_count,
                  rows[k].typed_mean);
      end
    end
  endtask

  // random register set, extremes included
  task automatic pick_settings();
    logic [wss_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 1;
      1: v = 32768;
      2: v = 65535;
      default: v = wss_pkg::CFG_DATA_W'($urandom_range(4000, 26000));
    endcase
    write_reg(wss_pkg::REG_DETECT_LEVEL, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = wss_pkg::CFG_DATA_W'($urandom_range(DEPTH + 1, 31));
      2: v = 1;
      3: v = DEPTH;
      default: v = wss_pkg::CFG_DATA_W'($urandom_range(1, DEPTH));
    endcase
    write_reg(wss_pkg::REG_WINDOW_LENGTH, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 1000000;
      2: v = wss_pkg::WARM_MAX;
      default: v = wss_pkg::CFG_DATA_W'($urandom_range(0, 60));
    endcase
    write_reg(wss_pkg::REG_WARMUP_FRAMES, v);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 60000;
      2: v = 65535;
      default: v = wss_pkg::CFG_DATA_W'($urandom_range(1, 3000));
    endcase
    write_reg(wss_pkg::REG_HOLDOFF_MS, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 31;
      2: v = 16;
      default: v = wss_pkg::CFG_DATA_W'($urandom_range(1, 4));
    endcase
    write_reg(wss_pkg::REG_FEATURE_STRIDE, v);
    settings_used++;
  endtask

  // speech-like bursts of high scores over low noise, time mostly moving forward
  task automatic send_random_beat();
    logic [wss_pkg::SCORE_W-1:0] raw;
    if ($urandom_range(0, 7) == 0) speaking = !speaking;
    case ($urandom_range(0, 19))
      0: raw = wss_pkg::SCORE_W'($urandom_range(32769, 65535));
      1: raw = wss_pkg::SCORE_W'($urandom_range(0, 65535));
      default: raw = speaking ? wss_pkg::SCORE_W'($urandom_range(20000, 32768))
                              : wss_pkg::SCORE_W'($urandom_range(0, 12000));
    endcase
    if ($urandom_range(0, 59) == 0 && clock_ms > 5000)
      clock_ms = clock_ms - wss_pkg::TIME_W'($urandom_range(1, 5000));
    else
      clock_ms = clock_ms + wss_pkg::TIME_W'($urandom_range(0, cool_r / 4 + 20));
    send_beat(raw, clock_ms, 1'b0, 2'd0, '0);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase_len;

    // warm-up at reset values, then the special cases one by one
    opening_rows.push_back(known_row(16'd0, 48'd0, 2'd1, 16'd0));
    opening_rows.push_back(known_row(16'd32768, 48'd1, 2'd1, 16'd0));
    opening_rows.push_back(known_row(16'd65535, 48'd2, 2'd1, 16'd0));
    opening_rows.push_back(known_row(16'd1, 48'd3, 2'd1, 16'd0));
    opening_rows.push_back(write_row(wss_pkg::REG_WARMUP_FRAMES, 20'd0));
    opening_rows.push_back(write_row(wss_pkg::REG_DETECT_LEVEL, 20'd32768));
    opening_rows.push_back(write_row(wss_pkg::REG_HOLDOFF_MS, 20'd0));
    opening_rows.push_back(write_row(wss_pkg::REG_WINDOW_LENGTH, 20'd1));
    opening_rows.push_back(item_row(16'd32768, 48'd10));
    opening_rows.push_back(item_row(16'd32768, 48'd10));
    opening_rows.push_back(item_row(16'd32768, 48'd10));
    opening_rows.push_back(item_row(16'd32767, 48'd11));
    opening_rows.push_back(write_row(wss_pkg::REG_DETECT_LEVEL, 20'd0));
    opening_rows.push_back(item_row(16'd0, 48'd12));
    opening_rows.push_back(write_row(wss_pkg::REG_HOLDOFF_MS, 20'd60000));
    opening_rows.push_back(item_row(16'd0, 48'd13));
    opening_rows.push_back(item_row(16'd0, 48'd60012));
    opening_rows.push_back(item_row(16'd0, 48'd60013));
    opening_rows.push_back(item_row(16'd0, 48'd5));
    opening_rows.push_back(write_row(wss_pkg::REG_WINDOW_LENGTH, 20'd0));
    opening_rows.push_back(item_row(16'd65535, 48'd200));
    opening_rows.push_back(write_row(wss_pkg::REG_WINDOW_LENGTH, 20'd31));
    opening_rows.push_back(item_row(16'd65535, 48'd201));
    opening_rows.push_back(write_row(wss_pkg::REG_WINDOW_LENGTH, 20'd16));
    opening_rows.push_back(item_row(16'd65535, 48'd202));
    opening_rows.push_back(write_row(wss_pkg::REG_FEATURE_STRIDE, 20'd0));
    opening_rows.push_back(write_row(wss_pkg::REG_WARMUP_FRAMES, 20'd100));
    opening_rows.push_back(item_row(16'd100, 48'd203));
    opening_rows.push_back(write_row(wss_pkg::REG_FEATURE_STRIDE, 20'd16));
    opening_rows.push_back(write_row(wss_pkg::REG_WARMUP_FRAMES, 20'd1000));
    opening_rows.push_back(item_row(16'd200, 48'd204));
    opening_rows.push_back(item_row(16'd300, 48'd205));
    opening_rows.push_back(write_row(wss_pkg::REG_WARMUP_FRAMES, 20'd30));
    opening_rows.push_back(item_row(16'd30000, 48'd120013));

    // top of the time range, last since the hold-off then stays out of reach
    closing_rows.push_back(write_row(wss_pkg::REG_DETECT_LEVEL, 20'd1));
    closing_rows.push_back(write_row(wss_pkg::REG_WARMUP_FRAMES, 20'd0));
    closing_rows.push_back(write_row(wss_pkg::REG_WINDOW_LENGTH, 20'd1));
    closing_rows.push_back(write_row(wss_pkg::REG_HOLDOFF_MS, 20'd0));
    closing_rows.push_back(item_row(16'd32768, TIME_MAX - 1));
    closing_rows.push_back(item_row(16'd32768, TIME_MAX - 1));
    closing_rows.push_back(item_row(16'd32768, TIME_MAX));
    closing_rows.push_back(write_row(wss_pkg::REG_HOLDOFF_MS, 20'd65535));
    closing_rows.push_back(item_row(16'd65535, TIME_MAX));
    closing_rows.push_back(item_row(16'd65535, TIME_MAX));
    closing_rows.push_back(item_row(16'd0, 48'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_rows(opening_rows);

    // random phases, each under its own register set and idling pattern
    random_sent = 0;
    while (random_sent < RANDOM_BEATS) begin
      settle();
      pick_settings();
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        send_random_beat();
        random_sent++;
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    send_gap_max = 4;
    stall_max = 4;
    run_rows(closing_rows);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d score beats under %0d random register sets plus directed cases",
             beats_sent, settings_used);
    $display("checked %0d score reports and %0d wake detections", reports_seen, detects_seen);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
